// ===== hdl/cfc_cell_forward_step_macros.svh =====
// Assertion helpers for the CfC cell block.
// Both forms sample on the block clock and are off while reset is held.
`ifndef CFC_CELL_FORWARD_STEP_MACROS_SVH
`define CFC_CELL_FORWARD_STEP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CFC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cfc check failed");

// The consequent holds in the cycle after the antecedent.
`define CFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cfc check failed");

`endif

// ===== hdl/cfc_pkg.sv =====
package cfc_pkg;

    // Network dimensions and number format.
    localparam int HIDDEN_UNITS    = 16;
    localparam int FRAC_BITS       = 12;
    localparam int ACT_TABLE_DEPTH = 256;

    // Parameter store layout.
    localparam int CONCAT_LEN  = HIDDEN_UNITS + 1;
    localparam int OFF_WG      = 0;
    localparam int OFF_BG      = OFF_WG + HIDDEN_UNITS * CONCAT_LEN;
    localparam int OFF_WC      = OFF_BG + HIDDEN_UNITS;
    localparam int OFF_BC      = OFF_WC + HIDDEN_UNITS * CONCAT_LEN;
    localparam int OFF_DECAY   = OFF_BC + HIDDEN_UNITS;
    localparam int OFF_WO      = OFF_DECAY + HIDDEN_UNITS;
    localparam int OFF_BO      = OFF_WO + HIDDEN_UNITS;
    localparam int PARAM_DEPTH = OFF_BO + 1;

    localparam int TABLE_STEP = 65536 / ACT_TABLE_DEPTH;
    localparam int IDX_W      = $clog2(ACT_TABLE_DEPTH);
    localparam int ONE_Q      = 1 << FRAC_BITS;

    // Widths of counters, addresses and the datapath.
    localparam int ADDR_W  = 10;
    localparam int MEM_AW  = $clog2(PARAM_DEPTH);
    localparam int CMP_W   = (MEM_AW > ADDR_W) ? MEM_AW : ADDR_W;
    localparam int UNIT_W  = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
    localparam int TERM_W  = $clog2(HIDDEN_UNITS + 2);
    localparam int MUL_A_W = 32;
    localparam int ACC_W   = 48;

    // Command codes.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef logic signed [15:0] t_q;

    typedef enum logic [1:0] {
        OP_ONE,
        OP_X,
        OP_H
    } t_opsel;

    typedef enum logic [1:0] {
        DEST_GATE,
        DEST_CAND,
        DEST_OUT
    } t_dest;

    typedef struct packed {
        logic clear;
        logic h_shift;
        logic g_shift;
        logic c_shift;
    } t_cell_ctl;

    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

    typedef logic [ACT_TABLE_DEPTH-1:0][15:0] t_act_table;

    // One table entry: tanh(u / 2^F) in Q F, built with integer exp(-2|u|).
    function automatic logic [15:0] tanh_entry(input longint u);
        longint unsigned a;
        longint unsigned y;
        longint unsigned t;
        longint unsigned r;
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned num;
        longint unsigned den;
        longint unsigned dvd;
        longint unsigned q;
        longint signed_q;
        int n;
        int b;
        a = longint'(u < 0 ? -u : u) * 2;
        if (a > (64'd24 << FRAC_BITS)) begin
            q = 64'(ONE_Q);
        end else begin
            y    = a << (32 - FRAC_BITS);
            t    = y >> 8;
            pos  = 64'd1 << 32;
            neg  = 0;
            term = 64'd1 << 32;
            for (n = 1; n <= 8; n++) begin
                term = (term * t) >> 32;
                case (n)
                    2: term = term / 2;
                    3: term = term / 3;
                    4: term = term / 4;
                    5: term = term / 5;
                    6: term = term / 6;
                    7: term = term / 7;
                    8: term = term / 8;
                    default: term = term;
                endcase
                if ((n % 2) == 1) begin
                    neg = neg + term;
                end else begin
                    pos = pos + term;
                end
            end
            r = pos - neg;
            if (r > 64'hFFFF_FFFF) begin
                r = 64'hFFFF_FFFF;
            end
            for (n = 0; n < 8; n++) begin
                r = (r * r + (64'd1 << 31)) >> 32;
            end
            num = (64'd1 << 32) - r;
            den = (64'd1 << 32) + r;
            // Rounded quotient by restoring long division.
            dvd = (num << FRAC_BITS) + (den >> 1);
            q   = 0;
            for (b = FRAC_BITS + 1; b >= 0; b--) begin
                if (dvd >= (den << b)) begin
                    dvd = dvd - (den << b);
                    q   = q | (64'd1 << b);
                end
            end
        end
        signed_q = (u < 0) ? -longint'(q) : longint'(q);
        return signed_q[15:0];
    endfunction

    function automatic t_act_table build_act_table();
        t_act_table tab;
        int k;
        for (k = 0; k < ACT_TABLE_DEPTH; k++) begin
            tab[k] = tanh_entry(longint'(k * TABLE_STEP + TABLE_STEP / 2 - 32768));
        end
        return tab;
    endfunction

    localparam t_act_table ACT_TABLE = build_act_table();

    // Table lookup: the index is the top bits of v offset to unsigned.
    function automatic t_q act_lookup(input t_q v);
        logic [15:0] off;
        off = {~v[15], v[14:0]};
        return t_q'(ACT_TABLE[off[15 -: IDX_W]]);
    endfunction

    // Round by adding half an LSB, shift down, saturate to 16 bits.
    function automatic t_q round_sat(input logic signed [ACC_W-1:0] v, input int unsigned s);
        logic signed [ACC_W-1:0] r;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sd32767);
        lo = ACC_W'(-32'sd32768);
        r  = (v + (ACC_W'(1) <<< (s - 1))) >>> s;
        if (r > hi) begin
            return 16'sh7FFF;
        end else if (r < lo) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

endpackage

// ===== hdl/cfc_if.sv =====
// Command channel: one load, step or clear item per transfer.
interface cfc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [cfc_pkg::ADDR_W-1:0]    param_address;
    logic signed [15:0]            param_value;
    logic signed [15:0]            sample;

    modport source (output valid, command, param_address, param_value, sample, input ready);
    modport sink   (input valid, command, param_address, param_value, sample, output ready);
endinterface

// Result channel: one prediction per step item.
interface cfc_pred_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] prediction;

    modport source (output valid, prediction, input ready);
    modport sink   (input valid, prediction, output ready);
endinterface

// ===== hdl/cfc_cell_forward_step.sv =====
// CfC recurrent cell, inference in signed Q4.12.
// Input channel i_cmd carries load, step and clear items. A load writes one
// word of the parameter memory (addresses past its end are dropped), a clear
// zeroes the hidden vector, a step takes one sample and yields one
// prediction on o_pred. Loads and clears take effect on their transfer.
// A step runs every multiply through one shared multiplier-accumulator:
// the gate and candidate rows of H+2 terms each issue one term a cycle,
// then the state update runs its sub-steps for each neuron, then the
// output row of H+1 terms issues; the pipeline drains after each row phase.
// The hidden vector sits in a chain of cells that rotates one place a cycle
// while its shift is enabled, so its head feeds the multiplier.
// The input is ready whenever no step is in progress, so loads and clears
// flow while a prediction waits. A finished prediction waits in the output
// register; if the previous one has not been taken, the block holds until
// it is. Reset empties the pipeline, drops any pending prediction and zeroes
// the hidden vector; the parameter memory keeps no reset value and must be
// loaded before the first step.
`include "cfc_cell_forward_step_macros.svh"

module cfc_cell_forward_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfc_cmd_if.sink     i_cmd,
    cfc_pred_if.source  o_pred
);

    localparam int H = cfc_pkg::HIDDEN_UNITS;
    localparam int F = cfc_pkg::FRAC_BITS;
    localparam int AW = cfc_pkg::MEM_AW;

    // Update sub-steps per neuron.
    localparam logic [2:0] US_KEEP_MUL = 3'd0;
    localparam logic [2:0] US_DECAY    = 3'd2;
    localparam logic [2:0] US_ADD      = 3'd3;
    localparam logic [2:0] US_WRITE    = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ROWS   = 7'b0000010,
        S_RDRAIN = 7'b0000100,
        S_UPD    = 7'b0001000,
        S_OUT    = 7'b0010000,
        S_ODRAIN = 7'b0100000,
        S_SEND   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [cfc_pkg::UNIT_W-1:0] r_unit, n_unit;
    logic                       r_kind, n_kind;
    logic [cfc_pkg::TERM_W-1:0] r_term, n_term;
    logic [AW-1:0]              r_gptr, n_gptr;
    logic [AW-1:0]              r_cptr, n_cptr;
    logic [2:0]                 r_us, n_us;

    // Issue stage.
    logic                r_a_valid, n_a_valid;
    logic [AW-1:0]       r_a_addr, n_a_addr;
    cfc_pkg::t_opsel     r_a_sel, n_a_sel;
    logic                r_a_first, n_a_first;
    logic                r_a_last, n_a_last;
    cfc_pkg::t_dest      r_a_dest, n_a_dest;

    // Memory data stage.
    logic                r_b_valid;
    cfc_pkg::t_opsel     r_b_sel;
    logic                r_b_first;
    logic                r_b_last;
    cfc_pkg::t_dest      r_b_dest;
    cfc_pkg::t_q         r_mem_q;

    // Product, sum and activation stages.
    logic                r_c_valid;
    cfc_pkg::t_dest      r_c_dest;
    logic                r_d_valid;
    cfc_pkg::t_dest      r_d_dest;
    logic                r_e_valid;
    cfc_pkg::t_dest      r_e_dest;
    cfc_pkg::t_q         r_e_pre;

    cfc_pkg::t_q         r_x;
    cfc_pkg::t_q         r_y;
    cfc_pkg::t_q         r_pred;
    logic                r_out_valid;

    cfc_pkg::t_q         r_mem [cfc_pkg::PARAM_DEPTH];

    logic                in_xfer;
    logic                out_xfer;
    logic                mem_we;
    logic [cfc_pkg::CMP_W-1:0] wr_ext;
    logic                pipe_busy;

    cfc_pkg::t_cell_ctl  cell_ctl;
    cfc_pkg::t_mac_ctl   mac_ctl;
    logic signed [cfc_pkg::MUL_A_W-1:0] mac_a;
    cfc_pkg::t_q         mac_b;
    logic signed [cfc_pkg::ACC_W-1:0] mac_acc;

    cfc_pkg::t_q         w_h [H];
    cfc_pkg::t_q         w_g [H];
    cfc_pkg::t_q         w_c [H];
    cfc_pkg::t_q         tail_h, tail_g, tail_c;
    cfc_pkg::t_q         new_h;

    cfc_pkg::t_q         e_half;
    cfc_pkg::t_q         e_tanh_half;
    logic signed [17:0]  e_sum;
    cfc_pkg::t_q         e_gate;
    cfc_pkg::t_q         e_cand;
    logic signed [cfc_pkg::MUL_A_W-1:0] one_minus_g;

    assign in_xfer   = i_cmd.valid && i_cmd.ready;
    assign out_xfer  = o_pred.valid && o_pred.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign o_pred.valid      = r_out_valid;
    assign o_pred.prediction = r_pred;

    assign wr_ext = cfc_pkg::CMP_W'(i_cmd.param_address);
    assign mem_we = in_xfer && (i_cmd.command == cfc_pkg::CMD_LOAD)
                    && (32'(wr_ext) < cfc_pkg::PARAM_DEPTH);

    assign pipe_busy = r_a_valid || r_b_valid || r_c_valid || r_d_valid || r_e_valid;

    // Parameter memory, one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_ext[AW-1:0]] <= i_cmd.param_value;
        end
        r_mem_q <= r_mem[r_a_addr];
    end

    // Chain of neuron cells; cell 0 is the head that feeds the multiplier.
    for (genvar gi = 0; gi < H; gi++) begin : g_cells
        if (gi == H - 1) begin : g_tail
            cfc_cell u_cell (
                .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (cell_ctl),
                .i_h (tail_h), .i_g (tail_g), .i_c (tail_c),
                .o_h (w_h[gi]), .o_g (w_g[gi]), .o_c (w_c[gi])
            );
        end else begin : g_body
            cfc_cell u_cell (
                .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctl (cell_ctl),
                .i_h (w_h[gi+1]), .i_g (w_g[gi+1]), .i_c (w_c[gi+1]),
                .o_h (w_h[gi]), .o_g (w_g[gi]), .o_c (w_c[gi])
            );
        end
    end

    cfc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (mac_acc)
    );

    // Activations of a finished pre-activation.
    assign e_half      = r_e_pre >>> 1;
    assign e_tanh_half = cfc_pkg::act_lookup(e_half);
    assign e_sum       = 18'(cfc_pkg::ONE_Q) + 18'(e_tanh_half) + 18'sd1;
    assign e_gate      = 16'(e_sum >>> 1);
    assign e_cand      = cfc_pkg::act_lookup(r_e_pre);

    assign one_minus_g = cfc_pkg::MUL_A_W'(cfc_pkg::ONE_Q) - cfc_pkg::MUL_A_W'(w_g[0]);
    assign new_h       = cfc_pkg::round_sat(mac_acc, 2 * F);

    // Multiplier operands: row terms from the data stage, else update steps.
    always_comb begin
        mac_ctl = '0;
        mac_a   = cfc_pkg::MUL_A_W'(r_mem_q);
        case (r_b_sel)
            cfc_pkg::OP_ONE: mac_b = 16'(cfc_pkg::ONE_Q);
            cfc_pkg::OP_X:   mac_b = r_x;
            default:         mac_b = w_h[0];
        endcase
        if (r_state == S_UPD) begin
            case (r_us)
                US_KEEP_MUL: begin
                    mac_ctl = '{valid: 1'b1, first: 1'b1};
                    mac_a   = one_minus_g;
                    mac_b   = w_h[0];
                end
                US_DECAY: begin
                    mac_ctl = '{valid: 1'b1, first: 1'b1};
                    mac_a   = mac_acc[cfc_pkg::MUL_A_W-1:0];
                    mac_b   = r_mem_q;
                end
                US_ADD: begin
                    mac_ctl = '{valid: 1'b1, first: 1'b0};
                    mac_a   = cfc_pkg::MUL_A_W'(w_g[0]) <<< F;
                    mac_b   = w_c[0];
                end
                default: mac_ctl = '0;
            endcase
        end else begin
            mac_ctl = '{valid: r_b_valid, first: r_b_first};
        end
    end

    // Cell chain control and the values entering its tail.
    always_comb begin
        cell_ctl = '0;
        tail_h   = w_h[0];
        tail_g   = r_e_valid ? e_gate : w_g[0];
        tail_c   = r_e_valid ? e_cand : w_c[0];
        cell_ctl.clear   = in_xfer && (i_cmd.command == cfc_pkg::CMD_CLEAR);
        cell_ctl.h_shift = r_b_valid && (r_b_sel == cfc_pkg::OP_H);
        cell_ctl.g_shift = r_e_valid && (r_e_dest == cfc_pkg::DEST_GATE);
        cell_ctl.c_shift = r_e_valid && (r_e_dest == cfc_pkg::DEST_CAND);
        if (r_state == S_UPD && r_us == US_WRITE) begin
            cell_ctl.h_shift = 1'b1;
            cell_ctl.g_shift = 1'b1;
            cell_ctl.c_shift = 1'b1;
            tail_h           = new_h;
        end
    end

    // Sequencer: row issue, update steps and output row.
    always_comb begin
        n_state   = r_state;
        n_unit    = r_unit;
        n_kind    = r_kind;
        n_term    = r_term;
        n_gptr    = r_gptr;
        n_cptr    = r_cptr;
        n_us      = r_us;
        n_a_valid = 1'b0;
        n_a_addr  = r_a_addr;
        n_a_sel   = cfc_pkg::OP_ONE;
        n_a_first = 1'b0;
        n_a_last  = 1'b0;
        n_a_dest  = cfc_pkg::DEST_GATE;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && i_cmd.command == cfc_pkg::CMD_STEP) begin
                    n_state = S_ROWS;
                    n_unit  = '0;
                    n_kind  = 1'b0;
                    n_term  = '0;
                    n_gptr  = AW'(cfc_pkg::OFF_WG);
                    n_cptr  = AW'(cfc_pkg::OFF_WC);
                end
            end
            S_ROWS: begin
                n_a_valid = 1'b1;
                n_a_dest  = r_kind ? cfc_pkg::DEST_CAND : cfc_pkg::DEST_GATE;
                n_a_first = (r_term == '0);
                n_a_last  = (r_term == cfc_pkg::TERM_W'(H + 1));
                if (r_term == '0) begin
                    n_a_sel  = cfc_pkg::OP_ONE;
                    n_a_addr = (r_kind ? AW'(cfc_pkg::OFF_BC) : AW'(cfc_pkg::OFF_BG))
                               + AW'(r_unit);
                end else begin
                    n_a_sel = (r_term == cfc_pkg::TERM_W'(1)) ? cfc_pkg::OP_X : cfc_pkg::OP_H;
                    if (r_kind) begin
                        n_a_addr = r_cptr;
                        n_cptr   = r_cptr + AW'(1);
                    end else begin
                        n_a_addr = r_gptr;
                        n_gptr   = r_gptr + AW'(1);
                    end
                end
                if (n_a_last) begin
                    n_term = '0;
                    n_kind = ~r_kind;
                    if (r_kind) begin
                        n_unit = r_unit + cfc_pkg::UNIT_W'(1);
                        if (r_unit == cfc_pkg::UNIT_W'(H - 1)) begin
                            n_state = S_RDRAIN;
                        end
                    end
                end else begin
                    n_term = r_term + cfc_pkg::TERM_W'(1);
                end
            end
            S_RDRAIN: begin
                if (!pipe_busy) begin
                    n_state  = S_UPD;
                    n_unit   = '0;
                    n_us     = '0;
                    n_a_addr = AW'(cfc_pkg::OFF_DECAY);
                end
            end
            S_UPD: begin
                if (r_us == US_WRITE) begin
                    n_us     = '0;
                    n_unit   = r_unit + cfc_pkg::UNIT_W'(1);
                    n_a_addr = AW'(cfc_pkg::OFF_DECAY) + AW'(r_unit) + AW'(1);
                    if (r_unit == cfc_pkg::UNIT_W'(H - 1)) begin
                        n_state = S_OUT;
                        n_term  = '0;
                    end
                end else begin
                    n_us = r_us + 3'd1;
                end
            end
            S_OUT: begin
                n_a_valid = 1'b1;
                n_a_dest  = cfc_pkg::DEST_OUT;
                n_a_first = (r_term == '0);
                n_a_last  = (r_term == cfc_pkg::TERM_W'(H));
                if (r_term == '0) begin
                    n_a_sel  = cfc_pkg::OP_ONE;
                    n_a_addr = AW'(cfc_pkg::OFF_BO);
                end else begin
                    n_a_sel  = cfc_pkg::OP_H;
                    n_a_addr = AW'(cfc_pkg::OFF_WO) + AW'(r_term) - AW'(1);
                end
                if (n_a_last) begin
                    n_state = S_ODRAIN;
                end
                n_term = r_term + cfc_pkg::TERM_W'(1);
            end
            S_ODRAIN: begin
                if (!pipe_busy) begin
                    n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (!r_out_valid || o_pred.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_us      <= '0;
        end else begin
            r_state   <= n_state;
            r_a_valid <= n_a_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid && r_b_last;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_us      <= n_us;
            if (r_state == S_SEND && (!r_out_valid || o_pred.ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and counter registers.
    always_ff @(posedge i_clk) begin
        r_unit    <= n_unit;
        r_kind    <= n_kind;
        r_term    <= n_term;
        r_gptr    <= n_gptr;
        r_cptr    <= n_cptr;
        r_a_addr  <= n_a_addr;
        r_a_sel   <= n_a_sel;
        r_a_first <= n_a_first;
        r_a_last  <= n_a_last;
        r_a_dest  <= n_a_dest;
        r_b_sel   <= r_a_sel;
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_b_dest  <= r_a_dest;
        r_c_dest  <= r_b_dest;
        r_d_dest  <= r_c_dest;
        r_e_dest  <= r_d_dest;
        if (r_d_valid) begin
            r_e_pre <= cfc_pkg::round_sat(mac_acc, F);
        end
        if (in_xfer && i_cmd.command == cfc_pkg::CMD_STEP) begin
            r_x <= i_cmd.sample;
        end
        if (r_e_valid && r_e_dest == cfc_pkg::DEST_OUT) begin
            r_y <= r_e_pre;
        end
        if (r_state == S_SEND && (!r_out_valid || o_pred.ready)) begin
            r_pred <= r_y;
        end
    end

    // Checks on the step sequence.
    `CFC_ASSERT_NEXT(a_step_starts, in_xfer && i_cmd.command == cfc_pkg::CMD_STEP, r_state == S_ROWS)
    `CFC_ASSERT_NOW(a_out_in_drain, r_e_valid && r_e_dest == cfc_pkg::DEST_OUT, r_state == S_ODRAIN)
    `CFC_ASSERT_NOW(a_idle_quiet, r_state == S_IDLE, !r_b_valid && !r_e_valid)

endmodule

// ===== hdl/cfc_cell.sv =====
// One neuron slot of the chain: hidden value, gate and candidate.
// Each register takes the value on its input (the next cell's, or the tail value) when its shift enable is set.
module cfc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfc_pkg::t_cell_ctl i_ctl,
    input  cfc_pkg::t_q        i_h,
    input  cfc_pkg::t_q        i_g,
    input  cfc_pkg::t_q        i_c,
    output cfc_pkg::t_q        o_h,
    output cfc_pkg::t_q        o_g,
    output cfc_pkg::t_q        o_c
);

    cfc_pkg::t_q r_h;
    cfc_pkg::t_q r_g;
    cfc_pkg::t_q r_c;

    // The hidden value resets and clears to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_h <= '0;
        end else if (i_ctl.h_shift) begin
            r_h <= i_h;
        end
    end

    // Gate and candidate hold nothing meaningful until written.
    always_ff @(posedge i_clk) begin
        if (i_ctl.g_shift) begin
            r_g <= i_g;
        end
        if (i_ctl.c_shift) begin
            r_c <= i_c;
        end
    end

    assign o_h = r_h;
    assign o_g = r_g;
    assign o_c = r_c;

endmodule

// ===== hdl/cfc_mac.sv =====
// Shared multiplier-accumulator: a registered product, then the sum.
// A first term loads the accumulator, later terms add to it.
module cfc_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cfc_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [cfc_pkg::MUL_A_W-1:0]  i_a,
    input  cfc_pkg::t_q                         i_b,
    output logic signed [cfc_pkg::ACC_W-1:0]    o_acc
);

    logic signed [cfc_pkg::ACC_W-1:0] a_ext;
    logic signed [cfc_pkg::ACC_W-1:0] b_ext;
    logic signed [cfc_pkg::ACC_W-1:0] r_prod;
    logic signed [cfc_pkg::ACC_W-1:0] r_acc;
    logic                             r_pvalid;
    logic                             r_pfirst;

    assign a_ext = cfc_pkg::ACC_W'(i_a);
    assign b_ext = cfc_pkg::ACC_W'(i_b);

    // Product stage.
    always_ff @(posedge i_clk) begin
        r_prod <= a_ext * b_ext;
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pvalid <= i_ctl.valid;
            r_pfirst <= i_ctl.first;
        end
    end

    // Accumulate stage.
    always_ff @(posedge i_clk) begin
        if (r_pvalid) begin
            r_acc <= r_pfirst ? r_prod : r_acc + r_prod;
        end
    end

    assign o_acc = r_acc;

endmodule
